// ===== rtl/core/boot_record_checker_macros.svh =====
// Assertion macros for the boot record checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BOOT_RECORD_CHECKER_MACROS_SVH
`define BOOT_RECORD_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bcc_pkg.sv =====
// Shared types, constants and the CRC-32C byte step for the boot record checker.
// No dependencies.
package bcc_pkg;

  // record layout, byte offsets
  localparam logic [7:0] PosVer   = 8'd8;
  localparam logic [7:0] PosId0   = 8'd16;
  localparam logic [7:0] PosId1   = 8'd32;
  localparam logic [7:0] PosNode  = 8'd48;
  localparam logic [7:0] PosRows  = 8'd56;
  localparam logic [7:0] PosSeal  = 8'd60;
  localparam logic [7:0] PosVarb  = 8'd64;
  localparam logic [7:0] PosRsv   = 8'd96;
  localparam logic [7:0] PosTail  = 8'd124;
  localparam logic [7:0] PosEnd   = 8'd128;
  localparam logic [7:0] CntMax   = 8'd255;

  // bytes 16..95 go through the field shift line
  localparam int LineBytes = 80;
  localparam int LineTop   = 95;
  localparam int NumCount  = 7;

  localparam int NumStart [NumCount] = '{48, 56, 60, 64, 72, 80, 88};
  localparam int NumLen   [NumCount] = '{8, 4, 4, 8, 8, 8, 8};

  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // "CDBROOT1"
  localparam logic [7:0] MagicBytes [8] = '{8'h43, 8'h44, 8'h42, 8'h52,
                                            8'h4F, 8'h4F, 8'h54, 8'h31};
  // major 1, minor 0, size 128
  localparam logic [7:0] HdrBytes [8] = '{8'd1, 8'd0, 8'd0, 8'd0,
                                          8'd128, 8'd0, 8'd0, 8'd0};

  localparam int NumWords = 11;
  typedef logic [3:0] widx_t;
  localparam widx_t LastIdx = 4'd10;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_SIZE     = 3'd1,
    STS_CRC      = 3'd2,
    STS_MAGIC    = 3'd3,
    STS_VERSION  = 3'd4,
    STS_RESERVED = 3'd5,
    STS_DESC     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    EM_IDLE  = 3'b001,
    EM_JUDGE = 3'b010,
    EM_SEND  = 3'b100
  } emit_state_e;

  // byte routing from the capture unit to the CRC unit
  typedef struct packed {
    logic crc_en;
    logic tail_en;
  } pos_ctl_t;

  // per-record check results
  typedef struct packed {
    logic len_ok;
    logic magic_ok;
    logic version_ok;
    logic reserved_ok;
    logic desc_ok;
  } rec_flags_t;

  // one byte of reflected CRC-32C, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/bcc_in_if.sv =====
// Input channel of the boot record checker: one record byte per transfer.
// No dependencies.
interface bcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/bcc_out_if.sv =====
// Result channel of the boot record checker: one status/word per transfer.
// No dependencies.
interface bcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  word_index;
  logic [63:0] word_value;
  logic        last_result;

  modport source (output valid, output status, output word_index, output word_value,
                  output last_result, input ready);
  modport sink   (input valid, input status, input word_index, input word_value,
                  input last_result, output ready);
endinterface

// ===== rtl/core/bcc_crc.sv =====
// Byte-serial CRC-32C accumulator and stored checksum shift register.
// Depends on bcc_pkg.
module bcc_crc
  import bcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pos_ctl_t   ctl_i,
  input  logic [7:0] byte_i,
  input  logic       clr_i,
  output logic       crc_ok_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] stored_q, stored_d;

  always_comb begin
    crc_d    = crc_q;
    stored_d = stored_q;
    if (clr_i) begin
      crc_d    = CrcInit;
      stored_d = 32'd0;
    end else begin
      if (ctl_i.crc_en) crc_d = crc_byte(crc_q, byte_i);
      // little-endian: first tail byte ends up in the low byte
      if (ctl_i.tail_en) stored_d = {byte_i, stored_q[31:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcInit;
      stored_q <= 32'd0;
    end else begin
      crc_q    <= crc_d;
      stored_q <= stored_d;
    end
  end

  assign crc_ok_o = ((crc_q ^ CrcInit) == stored_q);

endmodule

// ===== rtl/core/bcc_capture.sv =====
// Byte counter, header checks and field shift line of the boot record checker.
// Depends on bcc_pkg.
module bcc_capture
  import bcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  input  logic        clr_i,
  input  widx_t       sel_i,
  output pos_ctl_t    ctl_o,
  output rec_flags_t  flags_o,
  output logic [63:0] word_o
);

  logic [7:0] cnt_q, cnt_d;
  logic       magic_ok_q, magic_ok_d;
  logic       ver_ok_q, ver_ok_d;
  logic       rsv_ok_q, rsv_ok_d;
  logic       id0_nz_q, id0_nz_d;
  logic       id1_nz_q, id1_nz_d;
  logic       ids_diff_q, ids_diff_d;
  logic [NumCount-1:0] lim_nz_q, lim_nz_d;
  logic [LineBytes-1:0][7:0] line_q, line_d;

  logic       absorb;
  logic       nz;
  logic [7:0] lim_off;
  logic [2:0] slot;
  logic [63:0] words [NumWords];

  assign absorb = take_i && (cnt_q < PosEnd);
  assign nz     = (byte_i != 8'd0);
  assign lim_off = cnt_q - PosVarb;

  always_comb begin
    if (cnt_q < PosRows) begin
      slot = 3'd0;
    end else if (cnt_q < PosSeal) begin
      slot = 3'd1;
    end else if (cnt_q < PosVarb) begin
      slot = 3'd2;
    end else begin
      slot = 3'd3 + {1'b0, lim_off[4:3]};
    end
  end

  always_comb begin
    ctl_o.crc_en  = absorb && (cnt_q < PosTail);
    ctl_o.tail_en = absorb && (cnt_q >= PosTail);
  end

  always_comb begin
    cnt_d      = cnt_q;
    magic_ok_d = magic_ok_q;
    ver_ok_d   = ver_ok_q;
    rsv_ok_d   = rsv_ok_q;
    id0_nz_d   = id0_nz_q;
    id1_nz_d   = id1_nz_q;
    ids_diff_d = ids_diff_q;
    lim_nz_d   = lim_nz_q;
    line_d     = line_q;
    if (clr_i) begin
      cnt_d      = 8'd0;
      magic_ok_d = 1'b1;
      ver_ok_d   = 1'b1;
      rsv_ok_d   = 1'b1;
      id0_nz_d   = 1'b0;
      id1_nz_d   = 1'b0;
      ids_diff_d = 1'b0;
      lim_nz_d   = '0;
    end else if (take_i) begin
      if (cnt_q != CntMax) cnt_d = cnt_q + 8'd1;
      if (absorb) begin
        if (cnt_q < PosVer) begin
          if (byte_i != MagicBytes[cnt_q[2:0]]) magic_ok_d = 1'b0;
        end else if (cnt_q < PosId0) begin
          if (byte_i != HdrBytes[cnt_q[2:0]]) ver_ok_d = 1'b0;
        end else if (cnt_q < PosRsv) begin
          line_d = {line_q[LineBytes-2:0], byte_i};
          if (cnt_q < PosId1) begin
            if (nz) id0_nz_d = 1'b1;
          end else if (cnt_q < PosNode) begin
            if (nz) id1_nz_d = 1'b1;
            // the matching byte of the first ID sits 16 places back
            if (byte_i != line_q[15]) ids_diff_d = 1'b1;
          end else begin
            if (nz) lim_nz_d[slot] = 1'b1;
          end
        end else if (cnt_q < PosTail) begin
          if (nz) rsv_ok_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= 8'd0;
      magic_ok_q <= 1'b1;
      ver_ok_q   <= 1'b1;
      rsv_ok_q   <= 1'b1;
      id0_nz_q   <= 1'b0;
      id1_nz_q   <= 1'b0;
      ids_diff_q <= 1'b0;
      lim_nz_q   <= '0;
    end else begin
      cnt_q      <= cnt_d;
      magic_ok_q <= magic_ok_d;
      ver_ok_q   <= ver_ok_d;
      rsv_ok_q   <= rsv_ok_d;
      id0_nz_q   <= id0_nz_d;
      id1_nz_q   <= id1_nz_d;
      ids_diff_q <= ids_diff_d;
      lim_nz_q   <= lim_nz_d;
    end
  end

  // payload only, fully rewritten by every full-length record
  always_ff @(posedge clk_i) begin
    line_q <= line_d;
  end

  always_comb begin
    flags_o.len_ok      = (cnt_q == PosEnd);
    flags_o.magic_ok    = magic_ok_q;
    flags_o.version_ok  = ver_ok_q;
    flags_o.reserved_ok = rsv_ok_q;
    flags_o.desc_ok     = id0_nz_q && id1_nz_q && ids_diff_q && (&lim_nz_q);
  end

  // record byte p sits at line_q[95 - p]
  always_comb begin
    for (int h = 0; h < 4; h++) begin
      for (int k = 0; k < 8; k++) begin
        // ID halves: first byte most significant
        words[h][8*(7-k) +: 8] = line_q[LineTop - 16 - 8*h - k];
      end
    end
    for (int n = 0; n < NumCount; n++) begin
      words[4+n] = 64'd0;
      for (int k = 0; k < 8; k++) begin
        if (k < NumLen[n]) words[4+n][8*k +: 8] = line_q[LineTop - NumStart[n] - k];
      end
    end
  end

  assign word_o = (sel_i <= LastIdx) ? words[sel_i] : 64'd0;

endmodule

// ===== rtl/core/bcc_emit.sv =====
// Verdict and result sequencer of the boot record checker.
// Depends on bcc_pkg and boot_record_checker_macros.svh.
`include "boot_record_checker_macros.svh"

module bcc_emit
  import bcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  rec_flags_t flags_i,
  input  logic       crc_ok_i,
  input  logic       res_ready_i,
  output logic       res_valid_o,
  output status_e    status_o,
  output widx_t      idx_o,
  output logic       last_o,
  output logic       busy_o,
  output logic       clr_o
);

  emit_state_e state_q, state_d;
  status_e     status_q, status_d;
  widx_t       idx_q, idx_d;
  logic        last_q, last_d;
  status_e     verdict;
  logic        res_fire;

  always_comb begin
    if (!flags_i.len_ok) begin
      verdict = STS_SIZE;
    end else if (!crc_ok_i) begin
      verdict = STS_CRC;
    end else if (!flags_i.magic_ok) begin
      verdict = STS_MAGIC;
    end else if (!flags_i.version_ok) begin
      verdict = STS_VERSION;
    end else if (!flags_i.reserved_ok) begin
      verdict = STS_RESERVED;
    end else if (!flags_i.desc_ok) begin
      verdict = STS_DESC;
    end else begin
      verdict = STS_OK;
    end
  end

  assign res_fire = res_valid_o && res_ready_i;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    idx_d    = idx_q;
    last_d   = last_q;
    clr_o    = 1'b0;
    case (state_q)
      EM_IDLE: begin
        if (start_i) state_d = EM_JUDGE;
      end
      EM_JUDGE: begin
        status_d = verdict;
        idx_d    = '0;
        last_d   = (verdict != STS_OK);
        state_d  = EM_SEND;
      end
      EM_SEND: begin
        if (res_fire) begin
          if (last_q) begin
            clr_o   = 1'b1;
            state_d = EM_IDLE;
          end else begin
            idx_d  = idx_q + widx_t'(1);
            last_d = ((idx_q + widx_t'(1)) == LastIdx);
          end
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EM_IDLE;
      status_q <= STS_OK;
      idx_q    <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      last_q   <= last_d;
    end
  end

  assign res_valid_o = (state_q == EM_SEND);
  assign status_o    = status_q;
  assign idx_o       = idx_q;
  assign last_o      = last_q;
  assign busy_o      = (state_q != EM_IDLE);

  `BCC_ASSERT_IMP(a_err_single, res_valid_o && (status_q != STS_OK), last_q && (idx_q == '0), "error result not single")
  `BCC_ASSERT_IMP(a_last_pos, res_valid_o && last_q, (idx_q == LastIdx) || (status_q != STS_OK), "last flag misplaced")
  `BCC_ASSERT_NXT(a_idx_step, res_fire && !last_q, res_valid_o && (idx_q == $past(idx_q) + widx_t'(1)), "word index skipped")

endmodule

// ===== rtl/core/boot_record_checker.sv =====
// Top level of the boot record checker: byte capture, CRC and result sequencer.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if, bcc_crc, bcc_capture, bcc_emit.
//
// Usage:
//   rec_i carries one record byte per transfer (data_byte, last_byte set on
//   the final byte). A record is 128 bytes; bytes 0..123 feed a CRC-32C that
//   must match the little-endian checksum in bytes 124..127.
//   res_o carries the verdict. A bad record gives one transfer with the error
//   status, word_index 0, word_value 0 and last_result set. A good record gives
//   eleven transfers, word_index 0..10, status 0, last_result on the eleventh.
// Timing:
//   Bytes are taken one per cycle while rec_i.ready is high, one 8-bit digit at
//   a time through the CRC step and the field shift line. After the last byte,
//   the judge state forms the verdict, then results go out at one per cycle
//   when res_o.ready is high. rec_i.ready stays low from the last byte until the
//   final result transfer, so no new record is taken while one is pending.
// Reset:
//   rst_ni clears the count, the CRC and all check flags; no clearing pass.
//   A stalled receiver simply holds the current result; input stays closed.
`include "boot_record_checker_macros.svh"

module boot_record_checker
  import bcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bcc_in_if.sink     rec_i,
  bcc_out_if.source  res_o
);

  pos_ctl_t    pos_ctl;
  rec_flags_t  flags;
  logic        crc_ok;
  logic        take;
  logic        clr;
  logic        busy;
  status_e     status;
  widx_t       idx;
  logic        last_res;
  logic [63:0] word;

  // input transfer
  assign rec_i.ready = !busy;
  assign take        = rec_i.valid && rec_i.ready;

  bcc_capture u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (rec_i.data_byte),
    .clr_i   (clr),
    .sel_i   (idx),
    .ctl_o   (pos_ctl),
    .flags_o (flags),
    .word_o  (word)
  );

  bcc_crc u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (pos_ctl),
    .byte_i   (rec_i.data_byte),
    .clr_i    (clr),
    .crc_ok_o (crc_ok)
  );

  // verdict is formed the cycle after the last byte is absorbed
  bcc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (take && rec_i.last_byte),
    .flags_i     (flags),
    .crc_ok_i    (crc_ok),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_o    (status),
    .idx_o       (idx),
    .last_o      (last_res),
    .busy_o      (busy),
    .clr_o       (clr)
  );

  // capture state is frozen while results go out, so the word mux is stable
  assign res_o.status      = status;
  assign res_o.word_index  = idx;
  assign res_o.word_value  = (status == STS_OK) ? word : 64'd0;
  assign res_o.last_result = last_res;

  `BCC_ASSERT_IMP(a_no_overlap, res_o.valid, !rec_i.ready, "input open while results pending")

endmodule
